// ===== src/aesbc_pkg.sv =====
// aesbc_pkg: shared types, constants and byte functions of the aes block cipher
// s-box table and inverse, mix-column helpers, beat structs and sequencer states
// no dependencies
package aesbc_pkg;

  localparam int BLOCK_BITS      = 128;
  localparam int ROUND_KEY_DEPTH = 60;
  localparam int RK_ROWS         = ROUND_KEY_DEPTH / 4;
  localparam int RK_AW           = $clog2(RK_ROWS);
  localparam int ROW_W           = 4;
  localparam int CFG_IDX_W       = 3;

  localparam logic [3:0] NK_BASE = 4'd4;
  localparam logic [3:0] NR_128  = 4'd10;
  localparam logic [3:0] NR_192  = 4'd12;
  localparam logic [3:0] NR_256  = 4'd14;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW     = 3'd7;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;
  localparam logic [1:0] MODE_OFB = 2'd3;

  localparam logic [1:0] KEY_LEN_256 = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEXP,
    S_LOAD,
    S_ARK,
    S_ROUND,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic decrypt;
    logic last;
  } rnd_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // inverse table folds to constants at synthesis
  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == b) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] d [4];
    logic [7:0] r [4];
    for (int k = 0; k < 4; k++) begin
      a[k] = col[31-8*k -: 8];
      d[k] = xt(a[k]);
    end
    r[0] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
    r[1] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
    r[2] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
    r[3] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
    return {r[0], r[1], r[2], r[3]};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a  [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] r  [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31-8*k -: 8];
      m2[k] = xt(a[k]);
      m4[k] = xt(m2[k]);
      m8[k] = xt(m4[k]);
      m9[k] = m8[k] ^ a[k];
      mb[k] = m8[k] ^ m2[k] ^ a[k];
      md[k] = m8[k] ^ m4[k] ^ a[k];
      me[k] = m8[k] ^ m4[k] ^ m2[k];
    end
    r[0] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
    r[1] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
    r[2] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
    r[3] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    return {r[0], r[1], r[2], r[3]};
  endfunction

endpackage

// ===== src/aesbc_ram.sv =====
// aesbc_ram: generic simple dual-port ram with registered read
// no dependencies
module aesbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/aesbc_round.sv =====
// aesbc_round: one aes round, forward or inverse, shared by every round
// depends on aesbc_pkg
module aesbc_round (
  input  logic [127:0]        state_in,
  input  logic [127:0]        rnd_key,
  input  aesbc_pkg::rnd_ctrl_t ctrl,
  output logic [127:0]        state_out
);
  import aesbc_pkg::*;

  logic [7:0]   s  [16];
  logic [7:0]   fs [16];
  logic [7:0]   is [16];
  logic [127:0] fwd_shift;
  logic [127:0] inv_sub;
  logic [127:0] fwd_mix;
  logic [127:0] inv_ark;
  logic [127:0] inv_mix;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fs[4*c+r] = sbox(s[4*((c+r)%4)+r]);
        // inverse shift then inverse s-box
        is[4*c+r] = inv_sbox(s[4*((c+4-r)%4)+r]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      fwd_shift[127-8*i -: 8] = fs[i];
      inv_sub[127-8*i -: 8]   = is[i];
    end
    inv_ark = inv_sub ^ rnd_key;
    for (int c = 0; c < 4; c++) begin
      fwd_mix[127-32*c -: 32] = mix_col(fwd_shift[127-32*c -: 32]);
      inv_mix[127-32*c -: 32] = inv_mix_col(inv_ark[127-32*c -: 32]);
    end
    if (ctrl.decrypt) begin
      state_out = ctrl.last ? inv_ark : inv_mix;
    end else begin
      state_out = (ctrl.last ? fwd_shift : fwd_mix) ^ rnd_key;
    end
  end

endmodule

// ===== src/aes_block_cipher_with_chaining.sv =====
// aes block cipher with ecb, cbc, cfb and ofb chaining; one round per cycle
// an accepted block runs load, add-round-key, nr rounds (nr = 10, 12, 14) and finish,
// which waits on a stalled output; after a key change key expansion runs first
// one block at a time on the single shared round unit: in_stall holds until idle
// reset: sync active low; clears control, config, chaining value and key state
// depends on aesbc_pkg, aesbc_ram, aesbc_round
module aes_block_cipher_with_chaining (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  aesbc_pkg::in_beat_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output aesbc_pkg::out_beat_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aesbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                        cfg_data
);
  import aesbc_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [1:0]   key_len_r;
  logic [1:0]   mode_r;
  logic [63:0]  key_r [4];
  logic [63:0]  iv_hi_r;
  logic [63:0]  iv_lo_r;
  logic         key_ready_r;

  logic [127:0] cv_r, cv_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] x_r;
  logic         op_r;
  logic         eng_dec_r;
  logic         last_r;
  logic [3:0]   rnd_r;
  logic [3:0]   nr_r;
  logic [3:0]   nk_r;

  logic [5:0]   wi_r;
  logic [2:0]   kc_r;
  logic [7:0]   rc_r;
  logic [31:0]  win_r [8];
  logic [95:0]  row_r;

  logic         out_valid_r;
  out_beat_t    out_r;

  logic         in_acc;
  logic         cfg_acc;
  logic         kexp_done;
  logic         out_free;
  logic [1:0]   kl_eff;
  logic [3:0]   nk_new;
  logic [31:0]  key_word;
  logic [31:0]  t_prev;
  logic [31:0]  sub_out;
  logic [31:0]  new_word;
  logic [2:0]   far_idx;
  logic         ram_we;
  logic [127:0] ram_rdata;
  logic [ROW_W-1:0] rd_row;
  logic         rk_oob_r;
  logic [127:0] rk;
  logic [127:0] round_out;
  logic [127:0] cv_use;
  logic [127:0] fin_cv;
  logic [127:0] fin_res;
  rnd_ctrl_t    rctrl;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  // an input beat waiting in idle takes the edge, so config never races a block
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // key schedule: one word per cycle over a window of the last eight words
  assign kl_eff   = (key_len_r > KEY_LEN_256) ? KEY_LEN_256 : key_len_r;
  assign nk_new   = NK_BASE + {1'b0, kl_eff, 1'b0};
  assign key_word = wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
  assign t_prev   = win_r[7];
  assign sub_out  = sub_word((kc_r == 3'd0) ? {t_prev[23:0], t_prev[31:24]} : t_prev);
  assign far_idx  = 3'(4'd8 - nk_r);
  assign kexp_done = (wi_r == {nr_r, 2'b11});

  always_comb begin
    if ({2'b00, wi_r} < {4'b0000, nk_r}) begin
      new_word = key_word;
    end else if (kc_r == 3'd0) begin
      new_word = win_r[far_idx] ^ sub_out ^ {rc_r, 24'h000000};
    end else if ((nk_r == 4'd8) && (kc_r == 3'd4)) begin
      new_word = win_r[far_idx] ^ sub_out;
    end else begin
      new_word = win_r[far_idx] ^ t_prev;
    end
  end

  assign ram_we = (state_r == S_KEXP) && (wi_r[1:0] == 2'b11) &&
                  (wi_r[5:2] < ROW_W'(RK_ROWS));

  always_comb begin
    unique case (state_r)
      S_LOAD:  rd_row = eng_dec_r ? nr_r : '0;
      S_ARK:   rd_row = eng_dec_r ? (nr_r - 4'd1) : 4'd1;
      S_ROUND: rd_row = eng_dec_r ? (nr_r - rnd_r - 4'd1) : (rnd_r + 4'd1);
      default: rd_row = '0;
    endcase
  end

  aesbc_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (RK_ROWS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r[RK_AW+1:2]),
    .wdata ({row_r, new_word}),
    .raddr (rd_row[RK_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rk = rk_oob_r ? '0 : ram_rdata;

  assign rctrl.decrypt = eng_dec_r;
  assign rctrl.last    = (rnd_r == nr_r);

  aesbc_round u_round (
    .state_in  (st_r),
    .rnd_key   (rk),
    .ctrl      (rctrl),
    .state_out (round_out)
  );

  // chaining around the cipher
  assign cv_use = in_data.first_block ? {iv_hi_r, iv_lo_r} : cv_r;

  always_comb begin
    fin_res = st_r;
    fin_cv  = cv_r;
    unique case (mode_r)
      MODE_ECB: begin
        fin_res = st_r;
      end
      MODE_CBC: begin
        if (op_r) begin
          fin_res = st_r ^ cv_r;
          fin_cv  = x_r;
        end else begin
          fin_res = st_r;
          fin_cv  = st_r;
        end
      end
      MODE_CFB: begin
        fin_res = st_r ^ x_r;
        fin_cv  = op_r ? x_r : (st_r ^ x_r);
      end
      MODE_OFB: begin
        fin_res = st_r ^ x_r;
        fin_cv  = st_r;
      end
      default: fin_res = st_r;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    cv_nxt = cv_r;
    if (in_acc) begin
      cv_nxt = cv_use;
      if ((mode_r == MODE_CBC) && !in_data.operation) begin
        st_nxt = {in_data.block_high, in_data.block_low} ^ cv_use;
      end else if ((mode_r == MODE_CFB) || (mode_r == MODE_OFB)) begin
        st_nxt = cv_use;
      end else begin
        st_nxt = {in_data.block_high, in_data.block_low};
      end
    end else if (state_r == S_ARK) begin
      st_nxt = st_r ^ rk;
    end else if (state_r == S_ROUND) begin
      st_nxt = round_out;
    end else if ((state_r == S_FIN) && out_free) begin
      cv_nxt = fin_cv;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = key_ready_r ? S_LOAD : S_KEXP;
      S_KEXP:  if (kexp_done) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_ARK;
      S_ARK:   state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == nr_r) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_len_r   <= '0;
      mode_r      <= MODE_ECB;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv_hi_r     <= '0;
      iv_lo_r     <= '0;
      key_ready_r <= 1'b0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
      nr_r        <= NR_128;
      nk_r        <= NK_BASE;
      rnd_r       <= '0;
      wi_r        <= '0;
      kc_r        <= '0;
      rc_r        <= 8'h01;
    end else begin
      state_r <= state_nxt;
      cv_r    <= cv_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_KEY_LENGTH: begin
            key_len_r   <= cfg_data[1:0];
            key_ready_r <= 1'b0;
          end
          CFG_CHAIN_MODE: mode_r <= cfg_data[1:0];
          CFG_KEY_0: begin
            key_r[0]    <= cfg_data;
            key_ready_r <= 1'b0;
          end
          CFG_KEY_1: begin
            key_r[1]    <= cfg_data;
            key_ready_r <= 1'b0;
          end
          CFG_KEY_2: begin
            key_r[2]    <= cfg_data;
            key_ready_r <= 1'b0;
          end
          CFG_KEY_3: begin
            key_r[3]    <= cfg_data;
            key_ready_r <= 1'b0;
          end
          CFG_IV_HIGH: iv_hi_r <= cfg_data;
          CFG_IV_LOW:  iv_lo_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && !key_ready_r) begin
        nk_r <= nk_new;
        nr_r <= nk_new + 4'd6;
        wi_r <= '0;
        kc_r <= '0;
        rc_r <= 8'h01;
      end else if (state_r == S_KEXP) begin
        wi_r <= wi_r + 6'd1;
        kc_r <= ({1'b0, kc_r} == nk_r - 4'd1) ? 3'd0 : kc_r + 3'd1;
        if (({2'b00, wi_r} >= {4'b0000, nk_r}) && (kc_r == 3'd0)) rc_r <= xt(rc_r);
        if (kexp_done) key_ready_r <= 1'b1;
      end
      if (state_r == S_ARK) begin
        rnd_r <= 4'd1;
      end else if (state_r == S_ROUND) begin
        rnd_r <= rnd_r + 4'd1;
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    st_r     <= st_nxt;
    rk_oob_r <= (rd_row >= ROW_W'(RK_ROWS));
    if (in_acc) begin
      x_r       <= {in_data.block_high, in_data.block_low};
      op_r      <= in_data.operation;
      eng_dec_r <= in_data.operation && ((mode_r == MODE_ECB) || (mode_r == MODE_CBC));
      last_r    <= in_data.last_block;
    end
    if (state_r == S_KEXP) begin
      for (int i = 0; i < 7; i++) win_r[i] <= win_r[i+1];
      win_r[7] <= new_word;
      row_r    <= {row_r[63:0], new_word};
    end
    if ((state_r == S_FIN) && out_free) begin
      out_r.result_high <= fin_res[127:64];
      out_r.result_low  <= fin_res[63:0];
      out_r.result_last <= last_r;
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result beat raised outside the finish step");

  a_round_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_ARK || state_r == S_ROUND) |-> key_ready_r)
    else $error("cipher running without an expanded key");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> (rnd_r != 4'd0) && (rnd_r <= nr_r))
    else $error("round counter out of range");

  a_kexp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KEXP |-> wi_r <= {nr_r, 2'b11})
    else $error("key expansion ran past the last word");

endmodule

// ===== tb/aes_block_cipher_with_chaining_tb.sv =====
// testbench for aes_block_cipher_with_chaining: directed table, then random messages
// predicts every block with its own aes key schedule, cipher and chaining modes
// depends on aesbc_pkg and the block under test
`timescale 1ns / 1ps

module aes_block_cipher_with_chaining_tb;
  import aesbc_pkg::*;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_ODD = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DIR_ROWS = 22;
  localparam logic [127:0] FIPS_PT = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FIPS_CT128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] FIPS_CT192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
  localparam logic [127:0] FIPS_CT256 = 128'h8ea2b7ca516745bfeafc49904b496089;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_block_cipher_with_chaining u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [1:0] klen_q, mode_q;
  logic [63:0] key_q [4];
  logic [63:0] iv_hi_q, iv_lo_q;
  logic [127:0] chain_q;
  logic schedule_ok;
  logic [31:0] rk_words [60];
  int nr_q;
  logic [7:0] inv_tbl [256];

  out_beat_t expected_blocks [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = xtime(a);
    end
    return r;
  endfunction

  function automatic logic [31:0] sub32(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  task automatic build_schedule();
    int nk, total;
    logic [7:0] rc;
    logic [31:0] t;
    logic [1:0] kl;
    kl = (klen_q == KLEN_ODD) ? KEY_LEN_256 : klen_q;
    nk = 4 + 2 * kl;
    nr_q = nk + 6;
    total = 4 * (nr_q + 1);
    rc = 8'h01;
    for (int i = 0; i < 8; i++)
      rk_words[i] = (i % 2) ? key_q[i / 2][31:0] : key_q[i / 2][63:32];
    for (int i = nk; i < total; i++) begin
      t = rk_words[i - 1];
      if (i % nk == 0) begin
        t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (nk == 8 && i % 8 == 4) begin
        t = sub32(t);
      end
      rk_words[i] = rk_words[i - nk] ^ t;
    end
    schedule_ok = 1'b1;
  endtask

  function automatic logic [127:0] add_round_key(input logic [127:0] s, input int rnd);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= rk_words[4*rnd + c];
    return s;
  endfunction

  // byte 4c+r sits at row r of column c
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int src, dst;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          src = 4*c + r;
          dst = 4*((c + r) % 4) + r;
          t[127-8*dst -: 8] = inv_tbl[s[127-8*src -: 8]];
        end else begin
          dst = 4*c + r;
          src = 4*((c + r) % 4) + r;
          t[127-8*dst -: 8] = SBOX[s[127-8*src -: 8]];
        end
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inv) begin
      coef[0] = 8'd14; coef[1] = 8'd11; coef[2] = 8'd13; coef[3] = 8'd9;
    end else begin
      coef[0] = 8'd2; coef[1] = 8'd3; coef[2] = 8'd1; coef[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], coef[(k + 4 - r) % 4]);
        s[127-8*(4*c+r) -: 8] = v;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
    s = add_round_key(s, 0);
    for (int rnd = 1; rnd <= nr_q; rnd++) begin
      s = sub_shift(s, 1'b0);
      if (rnd != nr_q) s = mix_all(s, 1'b0);
      s = add_round_key(s, rnd);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
    s = add_round_key(s, nr_q);
    for (int rnd = nr_q; rnd > 0; rnd--) begin
      s = sub_shift(s, 1'b1);
      s = add_round_key(s, rnd - 1);
      if (rnd != 1) s = mix_all(s, 1'b1);
    end
    return s;
  endfunction

  task automatic cipher_step(input in_beat_t b, output out_beat_t r);
    logic [127:0] x, s;
    if (!schedule_ok) build_schedule();
    if (b.first_block) chain_q = {iv_hi_q, iv_lo_q};
    x = {b.block_high, b.block_low};
    case (mode_q)
      MODE_ECB: s = (b.operation == OP_DEC) ? aes_decrypt(x) : aes_encrypt(x);
      MODE_CBC: begin
        if (b.operation == OP_DEC) begin
          s = aes_decrypt(x) ^ chain_q;
          chain_q = x;
        end else begin
          s = aes_encrypt(x ^ chain_q);
          chain_q = s;
        end
      end
      default: begin
        s = aes_encrypt(chain_q);
        if (mode_q == MODE_OFB) chain_q = s;
        s ^= x;
        // cfb feedback is always the ciphertext side
        if (mode_q == MODE_CFB) chain_q = (b.operation == OP_DEC) ? x : s;
      end
    endcase
    r.result_high = s[127:64];
    r.result_low = s[63:0];
    r.result_last = b.last_block;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_KEY_LENGTH: begin klen_q = val[1:0]; schedule_ok = 1'b0; end
      CFG_CHAIN_MODE: mode_q = val[1:0];
      CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: begin
        key_q[idx - CFG_KEY_0] = val;
        schedule_ok = 1'b0;
      end
      CFG_IV_HIGH: iv_hi_q = val;
      CFG_IV_LOW: iv_lo_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // send one beat; when known is set the typed-in result replaces the prediction
  task automatic send_block(input in_beat_t b, input bit known, input logic [127:0] want);
    out_beat_t r;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    cipher_step(b, r);
    if (known) r = '{want[127:64], want[63:0], b.last_block};
    expected_blocks.push_back(r);
    // beat taken, drop valid so it is not taken again
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_beat_t mk(input logic op, input logic [127:0] blk,
                                  input logic first, input logic last);
    return {op, blk, first, last};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick64();
    int k;
    k = $urandom_range(0, 7);
    return (k == 0) ? 64'h0 : (k == 1) ? '1 : rand64();
  endfunction

  typedef struct {
    logic [1:0] klen;
    logic [1:0] mode;
    in_beat_t beat;
    bit known;
    logic [127:0] want;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    in_beat_t b;
    logic [1:0] cur_klen, cur_mode;
    int sent, len, phase_items;
    logic op;

    for (int i = 0; i < 256; i++) inv_tbl[SBOX[i]] = 8'(i);
    klen_q = KLEN_128; mode_q = MODE_ECB;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    iv_hi_q = '0; iv_lo_q = '0; chain_q = '0; schedule_ok = 1'b0;

    dir_tab = '{
      '{KLEN_128, MODE_ECB, mk(OP_ENC, FIPS_PT, 1'b0, 1'b0), 1, FIPS_CT128},
      '{KLEN_128, MODE_ECB, mk(OP_DEC, FIPS_CT128, 1'b0, 1'b1), 1, FIPS_PT},
      '{KLEN_192, MODE_ECB, mk(OP_ENC, FIPS_PT, 1'b0, 1'b0), 1, FIPS_CT192},
      '{KLEN_192, MODE_ECB, mk(OP_DEC, FIPS_CT192, 1'b1, 1'b0), 1, FIPS_PT},
      '{KEY_LEN_256, MODE_ECB, mk(OP_ENC, FIPS_PT, 1'b0, 1'b0), 1, FIPS_CT256},
      '{KEY_LEN_256, MODE_ECB, mk(OP_DEC, FIPS_CT256, 1'b0, 1'b1), 1, FIPS_PT},
      // odd key length behaves as 256
      '{KLEN_ODD, MODE_ECB, mk(OP_ENC, FIPS_PT, 1'b1, 1'b1), 1, FIPS_CT256},
      '{KLEN_128, MODE_ECB, mk(OP_ENC, '0, 1'b0, 1'b0), 0, '0},
      '{KLEN_128, MODE_ECB, mk(OP_DEC, '1, 1'b0, 1'b0), 0, '0},
      // chain still holds the iv taken by the earlier first-block ecb rows
      '{KLEN_128, MODE_CBC, mk(OP_ENC, FIPS_PT, 1'b0, 1'b0), 0, '0},
      '{KLEN_128, MODE_CBC, mk(OP_ENC, '1, 1'b0, 1'b0), 0, '0},
      '{KLEN_128, MODE_CBC, mk(OP_DEC, FIPS_CT128, 1'b1, 1'b0), 0, '0},
      '{KLEN_128, MODE_CBC, mk(OP_DEC, '0, 1'b0, 1'b1), 0, '0},
      '{KLEN_192, MODE_CFB, mk(OP_ENC, FIPS_PT, 1'b1, 1'b0), 0, '0},
      '{KLEN_192, MODE_CFB, mk(OP_DEC, '1, 1'b0, 1'b0), 0, '0},
      '{KLEN_192, MODE_CFB, mk(OP_DEC, FIPS_PT, 1'b1, 1'b1), 0, '0},
      '{KEY_LEN_256, MODE_OFB, mk(OP_ENC, FIPS_PT, 1'b1, 1'b0), 0, '0},
      '{KEY_LEN_256, MODE_OFB, mk(OP_DEC, '0, 1'b0, 1'b0), 0, '0},
      '{KEY_LEN_256, MODE_OFB, mk(OP_ENC, '1, 1'b0, 1'b1), 0, '0},
      '{KEY_LEN_256, MODE_CBC, mk(OP_ENC, FIPS_PT, 1'b1, 1'b0), 0, '0},
      '{KEY_LEN_256, MODE_CBC, mk(OP_DEC, FIPS_CT256, 1'b0, 1'b0), 0, '0},
      '{KEY_LEN_256, MODE_CBC, mk(OP_ENC, '1, 1'b0, 1'b1), 0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_KEY_0, 64'h0001020304050607);
    write_reg(CFG_KEY_1, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_KEY_2, 64'h1011121314151617);
    write_reg(CFG_KEY_3, 64'h18191a1b1c1d1e1f);
    write_reg(CFG_IV_HIGH, 64'hf0e1d2c3b4a59687);
    write_reg(CFG_IV_LOW, 64'h78695a4b3c2d1e0f);
    write_reg(CFG_KEY_LENGTH, 64'(KLEN_128));
    write_reg(CFG_CHAIN_MODE, 64'(MODE_ECB));
    cur_klen = KLEN_128;
    cur_mode = MODE_ECB;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].klen != cur_klen || dir_tab[i].mode != cur_mode) begin
        wait_idle();
        if (dir_tab[i].klen != cur_klen) write_reg(CFG_KEY_LENGTH, 64'(dir_tab[i].klen));
        if (dir_tab[i].mode != cur_mode) write_reg(CFG_CHAIN_MODE, 64'(dir_tab[i].mode));
        cur_klen = dir_tab[i].klen;
        cur_mode = dir_tab[i].mode;
      end
      send_block(dir_tab[i].beat, dir_tab[i].known, dir_tab[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_KEY_0, pick64());
        write_reg(CFG_KEY_1, pick64());
        write_reg(CFG_KEY_2, pick64());
        write_reg(CFG_KEY_3, pick64());
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_IV_HIGH, pick64());
        write_reg(CFG_IV_LOW, pick64());
      end
      write_reg(CFG_KEY_LENGTH, 64'($urandom_range(0, 3)));
      write_reg(CFG_CHAIN_MODE, 64'($urandom_range(0, 3)));
      phase_items = $urandom_range(30, 90);
      while (phase_items > 0 && sent < RANDOM_ITEMS) begin
        len = $urandom_range(1, 8);
        op = 1'($urandom_range(0, 1));
        for (int j = 0; j < len; j++) begin
          b.operation = ($urandom_range(0, 9) == 0) ? ~op : op;
          b.block_high = rand64();
          b.block_low = rand64();
          b.first_block = (j == 0);
          b.last_block = (j == len - 1);
          // broken message framing now and then
          if ($urandom_range(0, 9) == 0) begin
            b.first_block = 1'($urandom_range(0, 1));
            b.last_block = 1'($urandom_range(0, 1));
          end
          send_block(b, 0, '0);
          sent++;
          phase_items--;
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_blocks.size() == 0)
      $display("aes_block_cipher_with_chaining_tb OK");
    else
      $display("aes_block_cipher_with_chaining_tb NOT OK");
    $finish;
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 9);
      repeat (n) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, out_data);
        errors++;
      end else begin
        e = expected_blocks.pop_front();
        if (out_data.result_high !== e.result_high) begin
          $display("%0t: result_high exp %h got %h", $realtime, e.result_high,
                   out_data.result_high);
          errors++;
        end
        if (out_data.result_low !== e.result_low) begin
          $display("%0t: result_low exp %h got %h", $realtime, e.result_low,
                   out_data.result_low);
          errors++;
        end
        if (out_data.result_last !== e.result_last) begin
          $display("%0t: result_last exp %b got %b", $realtime, e.result_last,
                   out_data.result_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("aes_block_cipher_with_chaining_tb NOT OK");
      $finish;
    end
  end

endmodule
